@@ hdl/aes128_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 package
// Shared types, constants, GF(2^8) byte functions and block-level round functions.
// ----------------------------------------------------------------------------
package aes128_pkg;

    localparam int NumRounds = 10;
    localparam int NumKeys   = NumRounds + 1;
    localparam int RndW      = 4;

    localparam logic ACT_ENCRYPT = 1'b0;
    localparam logic ACT_DECRYPT = 1'b1;

    localparam logic CFG_KEY_UPPER = 1'b0;
    localparam logic CFG_KEY_LOWER = 1'b1;

    typedef logic [127:0] blk_t;
    typedef blk_t [NumKeys-1:0] key_sched_t;

    // Control carried alongside each word through the round chain
    typedef struct packed {
        logic valid;
        logic act;
    } cell_ctl_t;

    function automatic logic [7:0] xtime(input logic [7:0] x);
        xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] t;
        acc = 8'h00;
        t   = a;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) acc = acc ^ t;
            t = xtime(t);
        end
        gmul = acc;
    endfunction

    function automatic logic [7:0] ginv(input logic [7:0] x);
        logic [7:0] acc;
        logic [7:0] base;
        acc  = 8'h01;
        base = x;
        // exponent 254 = 11111110b
        for (int k = 0; k < 8; k++) begin
            if (k != 0) acc = gmul(acc, base);
            base = gmul(base, base);
        end
        ginv = acc;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
        rotl8 = (x << n) | (x >> (8 - n));
    endfunction

    function automatic logic [7:0] sbox_calc(input logic [7:0] x);
        logic [7:0] v;
        v = ginv(x);
        sbox_calc = v ^ rotl8(v, 1) ^ rotl8(v, 2) ^ rotl8(v, 3) ^ rotl8(v, 4) ^ 8'h63;
    endfunction

    function automatic logic [7:0] isbox_calc(input logic [7:0] x);
        isbox_calc = ginv(rotl8(x, 1) ^ rotl8(x, 3) ^ rotl8(x, 6) ^ 8'h05);
    endfunction

    // Constant 256-entry tables, folded at elaboration
    typedef logic [255:0][7:0] sbox_tab_t;

    function automatic sbox_tab_t build_sbox(input logic inv);
        sbox_tab_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = inv ? isbox_calc(8'(i)) : sbox_calc(8'(i));
        end
        build_sbox = t;
    endfunction

    localparam sbox_tab_t SBOX  = build_sbox(1'b0);
    localparam sbox_tab_t ISBOX = build_sbox(1'b1);

    function automatic logic [7:0] sb(input logic [7:0] x);
        sb = SBOX[x];
    endfunction

    function automatic logic [7:0] isb(input logic [7:0] x);
        isb = ISBOX[x];
    endfunction

    // Byte i of a block, byte 0 most significant
    function automatic logic [7:0] byte_of(input blk_t b, input int i);
        byte_of = b[127-8*i -: 8];
    endfunction

    function automatic blk_t shift_fwd(input blk_t s);
        blk_t t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127-8*(r+4*c) -: 8] = byte_of(s, r + 4*((c+r) & 3));
        shift_fwd = t;
    endfunction

    function automatic blk_t shift_inv(input blk_t s);
        blk_t t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127-8*(r+4*((c+r) & 3)) -: 8] = byte_of(s, r + 4*c);
        shift_inv = t;
    endfunction

    function automatic blk_t mix_fwd(input blk_t s);
        blk_t t;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = byte_of(s, 4*c);   a1 = byte_of(s, 4*c+1);
            a2 = byte_of(s, 4*c+2); a3 = byte_of(s, 4*c+3);
            t[127-8*(4*c)   -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            t[127-8*(4*c+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            t[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            t[127-8*(4*c+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        mix_fwd = t;
    endfunction

    function automatic blk_t mix_inv(input blk_t s);
        blk_t t;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = byte_of(s, 4*c);   a1 = byte_of(s, 4*c+1);
            a2 = byte_of(s, 4*c+2); a3 = byte_of(s, 4*c+3);
            t[127-8*(4*c)   -: 8] = gmul(a0, 8'h0e) ^ gmul(a1, 8'h0b)
                                  ^ gmul(a2, 8'h0d) ^ gmul(a3, 8'h09);
            t[127-8*(4*c+1) -: 8] = gmul(a0, 8'h09) ^ gmul(a1, 8'h0e)
                                  ^ gmul(a2, 8'h0b) ^ gmul(a3, 8'h0d);
            t[127-8*(4*c+2) -: 8] = gmul(a0, 8'h0d) ^ gmul(a1, 8'h09)
                                  ^ gmul(a2, 8'h0e) ^ gmul(a3, 8'h0b);
            t[127-8*(4*c+3) -: 8] = gmul(a0, 8'h0b) ^ gmul(a1, 8'h0d)
                                  ^ gmul(a2, 8'h09) ^ gmul(a3, 8'h0e);
        end
        mix_inv = t;
    endfunction

    function automatic blk_t sub_fwd(input blk_t s);
        blk_t t;
        for (int i = 0; i < 16; i++) t[8*i +: 8] = sb(s[8*i +: 8]);
        sub_fwd = t;
    endfunction

    function automatic blk_t sub_inv(input blk_t s);
        blk_t t;
        for (int i = 0; i < 16; i++) t[8*i +: 8] = isb(s[8*i +: 8]);
        sub_inv = t;
    endfunction

endpackage

@@ hdl/aes128_key_exp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 key expansion
// Holds the cipher key and steps out one round key per cycle after a write.
// ----------------------------------------------------------------------------
module aes128_key_exp
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic                    cfg_index,
    input  logic                    cfg_hit,
    input  logic [63:0]             cfg_data,
    output logic                    busy,
    output aes128_pkg::key_sched_t  keys
);

    logic [63:0]                  key_upper_reg;
    logic [63:0]                  key_lower_reg;
    aes128_pkg::key_sched_t       keys_reg;
    logic [aes128_pkg::RndW-1:0]  step_reg, step_next;
    logic [7:0]                   rcon_reg, rcon_next;
    logic                         busy_reg, busy_next;
    aes128_pkg::blk_t             prev_key;
    aes128_pkg::blk_t             new_key;
    logic [31:0]                  tw;
    logic                         wr;

    assign cfg_ready = !busy_reg;
    assign wr        = cfg_valid && cfg_ready;
    assign busy      = busy_reg;
    assign keys      = keys_reg;

    // Form the next round key from the previous one
    always_comb
    begin
        prev_key = keys_reg[step_reg - aes128_pkg::RndW'(1)];
        tw = {aes128_pkg::sb(prev_key[23:16]) ^ rcon_reg, aes128_pkg::sb(prev_key[15:8]),
              aes128_pkg::sb(prev_key[7:0]), aes128_pkg::sb(prev_key[31:24])};
        new_key[127:96] = prev_key[127:96] ^ tw;
        new_key[95:64]  = prev_key[95:64]  ^ new_key[127:96];
        new_key[63:32]  = prev_key[63:32]  ^ new_key[95:64];
        new_key[31:0]   = prev_key[31:0]   ^ new_key[63:32];
    end

    // Advance the expansion counter
    always_comb
    begin
        step_next = step_reg;
        rcon_next = rcon_reg;
        busy_next = busy_reg;
        if (wr && cfg_hit) begin
            step_next = aes128_pkg::RndW'(1);
            rcon_next = 8'h01;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rcon_next = aes128_pkg::xtime(rcon_reg);
            if (step_reg == aes128_pkg::RndW'(aes128_pkg::NumRounds)) begin
                busy_next = 1'b0;
            end else begin
                step_next = step_reg + aes128_pkg::RndW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_upper_reg <= '0;
            key_lower_reg <= '0;
            step_reg      <= '0;
            rcon_reg      <= 8'h01;
            busy_reg      <= 1'b0;
        end else begin
            step_reg <= step_next;
            rcon_reg <= rcon_next;
            busy_reg <= busy_next;
            if (wr && cfg_hit && cfg_index == aes128_pkg::CFG_KEY_UPPER)
                key_upper_reg <= cfg_data;
            if (wr && cfg_hit && cfg_index == aes128_pkg::CFG_KEY_LOWER)
                key_lower_reg <= cfg_data;
        end
    end

    // Load round key 0 on a write, then one expanded key per cycle
    always_ff @(posedge clk)
    begin
        if (wr && cfg_hit) begin
            if (cfg_index == aes128_pkg::CFG_KEY_UPPER)
                keys_reg[0] <= {cfg_data, key_lower_reg};
            else
                keys_reg[0] <= {key_upper_reg, cfg_data};
        end else if (busy_reg) begin
            keys_reg[step_reg] <= new_key;
        end
    end

`ifndef SYNTHESIS
    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !cfg_ready)
        else $error("key write taken during expansion");
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (step_reg != 0 && step_reg <= aes128_pkg::RndW'(aes128_pkg::NumRounds)))
        else $error("expansion step out of range");
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (wr && cfg_hit) |=> (busy_reg && step_reg == aes128_pkg::RndW'(1)))
        else $error("expansion did not start");
`endif

endmodule

@@ hdl/aes128_round_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 round cell
// One registered round of either direction; hands its word to the next cell.
// ----------------------------------------------------------------------------
module aes128_round_cell
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   last,
    input  aes128_pkg::cell_ctl_t  ctl_in,
    input  aes128_pkg::blk_t       data_in,
    input  aes128_pkg::blk_t       key_enc,
    input  aes128_pkg::blk_t       key_dec,
    output aes128_pkg::cell_ctl_t  ctl_out,
    output aes128_pkg::blk_t       data_out
);

    aes128_pkg::cell_ctl_t ctl_reg;
    aes128_pkg::blk_t      data_reg, data_next;
    aes128_pkg::blk_t      t;

    // Encrypt: sub, shift, mix, add. Decrypt: shift, sub, add, mix. The last cell skips the mix.
    always_comb
    begin
        if (ctl_in.act == aes128_pkg::ACT_ENCRYPT) begin
            t = aes128_pkg::shift_fwd(aes128_pkg::sub_fwd(data_in));
            if (!last) t = aes128_pkg::mix_fwd(t);
            data_next = t ^ key_enc;
        end else begin
            t = aes128_pkg::sub_inv(aes128_pkg::shift_inv(data_in)) ^ key_dec;
            data_next = last ? t : aes128_pkg::mix_inv(t);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (adv)
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv) data_reg <= data_next;
    end

    assign ctl_out  = ctl_reg;
    assign data_out = data_reg;

endmodule

@@ hdl/aes128_block_cipher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block cipher
// Ten-cell round chain, one block per cycle in either direction unless stalled.
// ----------------------------------------------------------------------------
//  channel | signals                                        | dir
//  input   | in_valid, in_ready, action, block_upper/lower  | in
//  output  | out_valid, out_ready, result_upper/lower       | out
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data      | in
//
//  The path is an input register for the first AddRoundKey, then one cell per
//  round. A new word enters every cycle while the chain advances and no key
//  expansion runs. The chain advances whenever the last cell is empty or its
//  word is taken. After a key write, expansion steps out one round key per cycle.
//  Reset clears the key registers and all valid flags.
// ----------------------------------------------------------------------------
module aes128_block_cipher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [63:0] block_upper,
    input  logic [63:0] block_lower,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_upper,
    output logic [63:0] result_lower,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int N = aes128_pkg::NumRounds;

    aes128_pkg::key_sched_t keys;
    logic                   key_busy;
    logic                   adv;
    logic                   cfg_hit;
    aes128_pkg::cell_ctl_t  ctl   [N+1];
    aes128_pkg::blk_t       data  [N+1];
    aes128_pkg::cell_ctl_t  ctl0_reg;
    aes128_pkg::blk_t       data0_reg;
    aes128_pkg::blk_t       blk_in;

    assign cfg_hit = (cfg_index[63:1] == '0);

    aes128_key_exp u_key
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index[0]),
        .cfg_hit  (cfg_hit),
        .cfg_data (cfg_data),
        .busy     (key_busy),
        .keys     (keys)
    );

    // Advance the chain when the last word leaves or the slot is empty
    assign adv      = !ctl[N].valid || out_ready;
    assign in_ready = adv && !key_busy;
    assign blk_in   = {block_upper, block_lower};

    // Hold the input word after the first key addition
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl0_reg <= '0;
        else if (adv)
            ctl0_reg <= '{valid: in_valid && in_ready, act: action};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            data0_reg <= blk_in ^ ((action == aes128_pkg::ACT_ENCRYPT) ? keys[0] : keys[N]);
    end

    assign ctl[0]  = ctl0_reg;
    assign data[0] = data0_reg;

    for (genvar g = 0; g < N; g++) begin : g_cell
        aes128_round_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .last    (g == N - 1),
            .ctl_in  (ctl[g]),
            .data_in (data[g]),
            .key_enc (keys[g + 1]),
            .key_dec (keys[N - 1 - g]),
            .ctl_out (ctl[g + 1]),
            .data_out(data[g + 1])
        );
    end

    assign out_valid    = ctl[N].valid;
    assign result_upper = data[N][127:64];
    assign result_lower = data[N][63:0];

`ifndef SYNTHESIS
    a_no_in_keybusy: assert property (@(posedge clk) disable iff (!rst_n)
        key_busy |-> !in_ready)
        else $error("input taken during key expansion");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(result_upper)))
        else $error("stalled result changed");
    a_stall_no_in: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while chain stalled");
`endif

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block cipher testbench
// Sets the key through the register port, then sends directed and random
// blocks to encrypt and decrypt under random idling. Each result is compared
// with a typed-in answer or with a behavioral cipher computed in the bench.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LimitCycles = 2000000;
    localparam int NumRandom   = 1600;
    localparam int KeyIdx      = 2;
    localparam int SettleWait  = 30;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        action;
    logic [63:0] block_upper;
    logic [63:0] block_lower;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] result_upper;
    logic [63:0] result_lower;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [63:0] cfg_index;
    logic [63:0] cfg_data;

    // Bench copy of the key registers and expanded schedule
    logic [63:0]  key_hi;
    logic [63:0]  key_lo;
    logic [127:0] round_keys [aes128_pkg::NumKeys];
    logic [7:0]   sbox_fw [256];
    logic [7:0]   sbox_bw [256];

    logic [127:0] expected_blocks [$];

    int cycle_count;
    int mismatch_count;
    int words_sent;
    int words_checked;
    int enc_count;
    int dec_count;
    bit hold_off;

    // Directed stimulus: key, action, block, typed-in result or check-by-predictor
    typedef struct {
        logic [127:0] key;
        logic         act;
        logic [127:0] blk;
        bit           known;
        logic [127:0] res;
    } vector_t;

    vector_t vectors [$];

    aes128_block_cipher DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .block_upper  (block_upper),
        .block_lower  (block_lower),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_upper (result_upper),
        .result_lower (result_lower),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // ---------------- GF(2^8) arithmetic for the predictor ----------------
    function automatic logic [7:0] dbl(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] fmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k]) acc ^= a;
            a = dbl(a);
        end
        return acc;
    endfunction

    function automatic logic [7:0] rol(input logic [7:0] x, input int n);
        return (x << n) | (x >> (8 - n));
    endfunction

    // Fill forward and inverse substitution tables
    task automatic build_tables();
        logic [7:0] v;
        logic [7:0] p;
        for (int x = 0; x < 256; x++)
        begin
            v = 8'h00;
            // inverse by search; zero maps to zero
            for (int y = 1; y < 256; y++)
                if (fmul(8'(x), 8'(y)) == 8'h01) v = 8'(y);
            p = v ^ rol(v, 1) ^ rol(v, 2) ^ rol(v, 3) ^ rol(v, 4) ^ 8'h63;
            sbox_fw[x] = p;
            sbox_bw[p] = 8'(x);
        end
    endtask

    function automatic logic [7:0] bt(input logic [127:0] s, input int i);
        return s[127-8*i -: 8];
    endfunction

    // Expand the current key into eleven round keys
    task automatic expand_schedule();
        logic [31:0]  w [44];
        logic [31:0]  t;
        logic [7:0]   rc;
        logic [127:0] kk;
        rc = 8'h01;
        kk = {key_hi, key_lo};
        for (int i = 0; i < 4; i++) w[i] = kk[127-32*i -: 32];
        for (int i = 4; i < 44; i++)
        begin
            t = w[i-1];
            if (i % 4 == 0)
            begin
                t = {t[23:0], t[31:24]};
                t = {sbox_fw[t[31:24]] ^ rc, sbox_fw[t[23:16]],
                     sbox_fw[t[15:8]], sbox_fw[t[7:0]]};
                rc = dbl(rc);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int r = 0; r < aes128_pkg::NumKeys; r++)
            round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    endtask

    // Permute rows or mix columns for the direction chosen by inv
    function automatic logic [127:0] row_rotate(input logic [127:0] s, input bit inv);
        logic [127:0] t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                if (inv) t[127-8*(r+4*((c+r)%4)) -: 8] = bt(s, r + 4*c);
                else     t[127-8*(r+4*c) -: 8] = bt(s, r + 4*((c+r)%4));
        return t;
    endfunction

    function automatic logic [127:0] column_mix(input logic [127:0] s, input bit inv);
        logic [7:0]   m [4];
        logic [127:0] t;
        logic [7:0]   acc;
        if (inv) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        else     m = '{8'h02, 8'h03, 8'h01, 8'h01};
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                acc = 8'h00;
                for (int j = 0; j < 4; j++)
                    acc ^= fmul(bt(s, 4*c+j), m[(j-r+4)%4]);
                t[127-8*(4*c+r) -: 8] = acc;
            end
        return t;
    endfunction

    function automatic logic [127:0] cipher_block(input logic act, input logic [127:0] b);
        logic [127:0] s;
        s = b;
        if (act == aes128_pkg::ACT_ENCRYPT)
        begin
            s ^= round_keys[0];
            for (int r = 1; r <= aes128_pkg::NumRounds; r++)
            begin
                for (int i = 0; i < 16; i++) s[8*i +: 8] = sbox_fw[s[8*i +: 8]];
                s = row_rotate(s, 1'b0);
                if (r != aes128_pkg::NumRounds) s = column_mix(s, 1'b0);
                s ^= round_keys[r];
            end
        end
        else
        begin
            s ^= round_keys[aes128_pkg::NumRounds];
            for (int r = aes128_pkg::NumRounds - 1; r >= 0; r--)
            begin
                s = row_rotate(s, 1'b1);
                for (int i = 0; i < 16; i++) s[8*i +: 8] = sbox_bw[s[8*i +: 8]];
                s ^= round_keys[r];
                if (r != 0) s = column_mix(s, 1'b1);
            end
        end
        return s;
    endfunction

    // ---------------- Handshake tasks ----------------
    task automatic write_key_reg(input logic [63:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == 64'(aes128_pkg::CFG_KEY_UPPER))      key_hi = val;
        else if (idx == 64'(aes128_pkg::CFG_KEY_LOWER)) key_lo = val;
        expand_schedule();
        repeat (SettleWait) @(posedge clk);
    endtask

    task automatic load_key(input logic [127:0] k);
        write_key_reg(64'(aes128_pkg::CFG_KEY_UPPER), k[127:64]);
        write_key_reg(64'(aes128_pkg::CFG_KEY_LOWER), k[63:0]);
    endtask

    // Drop valid, then wait for every outstanding result
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_blocks.size() != 0) @(posedge clk);
        repeat (SettleWait) @(posedge clk);
    endtask

    // Offer one word, hold valid until taken; queue the expectation
    task automatic send_block(input logic act, input logic [127:0] b,
                              input bit known, input logic [127:0] res,
                              input bit idle);
        logic [127:0] pred;
        int           gap;
        gap = idle ? $urandom_range(0, 13) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pred = cipher_block(act, b);
        if (known && pred != res)
            $display("table row disagrees with predictor: %h", b);
        expected_blocks.push_back(known ? res : pred);
        in_valid    <= 1'b1;
        action      <= act;
        block_upper <= b[127:64];
        block_lower <= b[63:0];
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
        if (act == aes128_pkg::ACT_ENCRYPT) enc_count++; else dec_count++;
    endtask

    function automatic logic [127:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // ---------------- Result checking ----------------
    always @(posedge clk)
    begin
        logic [127:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_blocks.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word: expected none got %h_%h",
                             result_upper, result_lower);
            end
            else
            begin
                want = expected_blocks.pop_front();
                if (result_upper !== want[127:64] || result_lower !== want[63:0])
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %h_%h got %h_%h",
                                 want[127:64], want[63:0], result_upper, result_lower);
                end
                words_checked++;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Timeout guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LimitCycles)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------- Main sequence ----------------
    initial
    begin
        logic [127:0] fips_key;
        logic [127:0] b;
        bit           act;
        fips_key = 128'h000102030405060708090a0b0c0d0e0f;
        rst_n = 1'b0;
        in_valid = 1'b0; action = 1'b0; block_upper = '0; block_lower = '0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        cycle_count = 0; mismatch_count = 0; words_sent = 0; words_checked = 0;
        enc_count = 0; dec_count = 0; hold_off = 1'b0;
        key_hi = '0; key_lo = '0;
        build_tables();
        expand_schedule();

        // Known-answer rows first, then extremes checked by the predictor
        vectors.push_back('{fips_key, aes128_pkg::ACT_ENCRYPT,
                            128'h00112233445566778899aabbccddeeff,
                            1'b1, 128'h69c4e0d86a7b0430d8cdb78070b4c55a});
        vectors.push_back('{fips_key, aes128_pkg::ACT_DECRYPT,
                            128'h69c4e0d86a7b0430d8cdb78070b4c55a,
                            1'b1, 128'h00112233445566778899aabbccddeeff});
        vectors.push_back('{128'h2b7e151628aed2a6abf7158809cf4f3c, aes128_pkg::ACT_ENCRYPT,
                            128'h3243f6a8885a308d313198a2e0370734,
                            1'b1, 128'h3925841d02dc09fbdc118597196a0b32});
        vectors.push_back('{128'h0, aes128_pkg::ACT_ENCRYPT, 128'h0,
                            1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e});
        vectors.push_back('{128'h0, aes128_pkg::ACT_DECRYPT,
                            128'h66e94bd4ef8a2c3b884cfa59ca342b2e,
                            1'b1, 128'h0});
        vectors.push_back('{128'h0, aes128_pkg::ACT_ENCRYPT, {128{1'b1}}, 1'b0, 128'h0});
        vectors.push_back('{128'h0, aes128_pkg::ACT_DECRYPT, {128{1'b1}}, 1'b0, 128'h0});
        vectors.push_back('{{128{1'b1}}, aes128_pkg::ACT_ENCRYPT, 128'h0, 1'b0, 128'h0});
        vectors.push_back('{{128{1'b1}}, aes128_pkg::ACT_DECRYPT, 128'h0, 1'b0, 128'h0});
        vectors.push_back('{{128{1'b1}}, aes128_pkg::ACT_ENCRYPT, {128{1'b1}},
                            1'b0, 128'h0});
        vectors.push_back('{{128{1'b1}}, aes128_pkg::ACT_DECRYPT, {128{1'b1}},
                            1'b0, 128'h0});
        vectors.push_back('{{64'h0, {64{1'b1}}}, aes128_pkg::ACT_ENCRYPT,
                            {{64{1'b1}}, 64'h0}, 1'b0, 128'h0});
        vectors.push_back('{{64'h0, {64{1'b1}}}, aes128_pkg::ACT_DECRYPT,
                            {64'h0, {64{1'b1}}}, 1'b0, 128'h0});

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the table, reloading the key when it changes
        load_key(vectors[0].key);
        foreach (vectors[i])
        begin
            if ({key_hi, key_lo} != vectors[i].key)
            begin
                drain_results();
                load_key(vectors[i].key);
            end
            send_block(vectors[i].act, vectors[i].blk, vectors[i].known,
                       vectors[i].res, 1'b0);
        end
        drain_results();

        // Write only one half, then an out-of-range index that must be ignored
        write_key_reg(64'(aes128_pkg::CFG_KEY_LOWER), 64'h0123456789abcdef);
        send_block(aes128_pkg::ACT_ENCRYPT, rand128(), 1'b0, 128'h0, 1'b0);
        drain_results();
        write_key_reg(64'(KeyIdx), 64'hdeadbeefdeadbeef);
        send_block(aes128_pkg::ACT_DECRYPT, rand128(), 1'b0, 128'h0, 1'b0);
        drain_results();

        // Random phases, each under a fresh key
        for (int phase = 0; phase < 8; phase++)
        begin
            load_key(rand128());
            if (phase == 2) hold_off = 1'b1;
            for (int n = 0; n < NumRandom / 8; n++)
            begin
                act = 1'($urandom_range(0, 1));
                b = rand128();
                // back-to-back bursts without idling in half the phases
                send_block(act, b, 1'b0, 128'h0, (phase % 2) == 0);
            end
            drain_results();
        end

        drain_results();
        $display("Sent %0d words (%0d encrypt, %0d decrypt), checked %0d results",
                 words_sent, enc_count, dec_count, words_checked);
        $display("Key changes covered all-zero, all-one, half-written and random keys");
        if (mismatch_count == 0 && expected_blocks.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ files.f @@
hdl/aes128_pkg.sv
hdl/aes128_key_exp.sv
hdl/aes128_round_cell.sv
hdl/aes128_block_cipher.sv
test/testbench.sv
